### hw/rtl/las_pkg.sv
// las_pkg: shared types, constants and character-class helpers for the
// loop attribute scanner; no dependencies
package las_pkg;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 32;
    localparam int COUNT_W = 34;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd32;
    localparam logic [COUNT_W-1:0] COUNT_CAP   = 34'd1000000000;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_CONFLICT = 2'd1;
    localparam logic [1:0] VERDICT_OVER     = 2'd2;

    localparam logic KIND_UNROLL = 1'b0;
    localparam logic KIND_LOOP   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } las_item_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return c inside {8'h20, 8'h09, 8'h0d, 8'h0a};
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_ident(input logic [BYTE_W-1:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], 8'h5f};
    endfunction

    function automatic logic [2:0] kw_len(input logic kind);
        return (kind == KIND_LOOP) ? 3'd4 : 3'd6;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic kind, input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        ch = 8'h00;
        if (kind == KIND_LOOP)
        begin
            case (pos)
                3'd0:    ch = "l";
                3'd1:    ch = "o";
                3'd2:    ch = "o";
                3'd3:    ch = "p";
                default: ch = 8'h00;
            endcase
        end
        else
        begin
            case (pos)
                3'd0:    ch = "u";
                3'd1:    ch = "n";
                3'd2:    ch = "r";
                3'd3:    ch = "o";
                3'd4:    ch = "l";
                3'd5:    ch = "l";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

### hw/rtl/las_in_reg.sv
// las_in_reg: input register stage for the byte channel
// depends on las_pkg
module las_in_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  las_pkg::las_item_t    in_item,
    output logic                  item_valid,
    input  logic                  item_ready,
    output las_pkg::las_item_t    item
);
    import las_pkg::*;

    logic      valid_reg;
    las_item_t item_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### hw/rtl/las_scan.sv
// las_scan: scan state machine, count accumulator and result register
// depends on las_pkg
module las_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  las_pkg::las_item_t             item,
    input  logic [las_pkg::LIMIT_W-1:0]    limit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     verdict,
    output logic                           saw_unroll,
    output logic                           saw_loop,
    output logic                           saw_count,
    output logic [las_pkg::COUNT_W-1:0]    unroll_count
);
    import las_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_KW,
        PH_AFTKW,
        PH_ARG,
        PH_DIGITS
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               kind_reg, kind_next;
    logic [2:0]         pos_reg, pos_next;
    logic               unroll_reg, unroll_next;
    logic               loop_reg, loop_next;
    logic               paren_reg, paren_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] stored_reg, stored_next;

    logic               out_valid_reg;
    logic [1:0]         verdict_reg, verdict_next;
    logic               fin_unroll, fin_loop;
    logic [1:0]         res_verdict;

    logic [BYTE_W-1:0]  c;
    logic               take;
    logic               do_after;
    logic               do_digit;

    assign c          = item.code;
    assign item_ready = !item.last || !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        unroll_next = unroll_reg;
        loop_next   = loop_reg;
        paren_next  = paren_reg;
        acc_next    = acc_reg;
        stored_next = stored_reg;
        do_after    = 1'b0;
        do_digit    = 1'b0;

        if (c == "[")
        begin
            if (phase_reg == PH_KW && pos_reg == kw_len(kind_reg))
            begin
                if (kind_reg == KIND_LOOP)
                    loop_next = 1'b1;
                else
                    unroll_next = 1'b1;
            end
            phase_next = PH_OPEN;
            pos_next   = 3'd0;
        end
        else
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    if (is_ws(c))
                    begin
                        phase_next = PH_OPEN;
                    end
                    else if (c == "u")
                    begin
                        kind_next  = KIND_UNROLL;
                        pos_next   = 3'd1;
                        phase_next = PH_KW;
                    end
                    else if (c == "l")
                    begin
                        kind_next  = KIND_LOOP;
                        pos_next   = 3'd1;
                        phase_next = PH_KW;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_KW:
                begin
                    if (pos_reg < kw_len(kind_reg))
                    begin
                        if (c == kw_char(kind_reg, pos_reg))
                            pos_next = pos_reg + 3'd1;
                        else
                            phase_next = PH_IDLE;
                    end
                    else if (is_ident(c))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (kind_reg == KIND_LOOP)
                    begin
                        loop_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        unroll_next = 1'b1;
                        do_after    = 1'b1;
                    end
                end
                PH_AFTKW:
                begin
                    do_after = 1'b1;
                end
                PH_ARG:
                begin
                    if (is_ws(c))
                    begin
                        phase_next = PH_ARG;
                    end
                    else if (is_digit(c))
                    begin
                        do_digit   = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit(c))
                        do_digit = 1'b1;
                    else
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // whitespace or argument after the unroll keyword
        if (do_after)
        begin
            if (is_ws(c))
            begin
                phase_next = PH_AFTKW;
            end
            else if (c == "(")
            begin
                paren_next = 1'b1;
                acc_next   = '0;
                phase_next = PH_ARG;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end

        // times ten plus digit, held once the cap is reached
        if (do_digit)
        begin
            if (acc_reg < COUNT_CAP)
                acc_next = (acc_reg << 3) + (acc_reg << 1)
                         + {{(COUNT_W-4){1'b0}}, c[3:0]};
            stored_next = acc_next;
        end
    end

    // verdict for a transaction that ends the prefix
    always_comb
    begin
        fin_unroll = unroll_next;
        fin_loop   = loop_next;
        if (phase_next == PH_KW && pos_next == kw_len(kind_next))
        begin
            if (kind_next == KIND_LOOP)
                fin_loop = 1'b1;
            else
                fin_unroll = 1'b1;
        end
        if (fin_unroll && fin_loop)
            res_verdict = VERDICT_CONFLICT;
        else if (paren_next && stored_next > {{(COUNT_W-LIMIT_W){1'b0}}, limit})
            res_verdict = VERDICT_OVER;
        else
            res_verdict = VERDICT_NONE;
        verdict_next = res_verdict;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_UNROLL;
            pos_reg       <= 3'd0;
            unroll_reg    <= 1'b0;
            loop_reg      <= 1'b0;
            paren_reg     <= 1'b0;
            acc_reg       <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_NONE;
            saw_unroll    <= 1'b0;
            saw_loop      <= 1'b0;
            saw_count     <= 1'b0;
            unroll_count  <= '0;
        end
        else
        begin
            if (take && item.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                if (item.last)
                begin
                    phase_reg     <= PH_IDLE;
                    kind_reg      <= KIND_UNROLL;
                    pos_reg       <= 3'd0;
                    unroll_reg    <= 1'b0;
                    loop_reg      <= 1'b0;
                    paren_reg     <= 1'b0;
                    acc_reg       <= '0;
                    stored_reg    <= '0;
                    verdict_reg   <= verdict_next;
                    saw_unroll    <= fin_unroll;
                    saw_loop      <= fin_loop;
                    saw_count     <= paren_next;
                    unroll_count  <= stored_next;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    kind_reg   <= kind_next;
                    pos_reg    <= pos_next;
                    unroll_reg <= unroll_next;
                    loop_reg   <= loop_next;
                    paren_reg  <= paren_next;
                    acc_reg    <= acc_next;
                    stored_reg <= stored_next;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

### hw/rtl/loop_attribute_scanner.sv
// loop_attribute_scanner: scans prefix bytes for unroll and loop attributes
// result path: the last byte of a prefix passes the input register, then the scan sets the result register
// throughput: one byte per cycle while no held result stalls input, set by the single-pass scan step and count update
// a held result stalls input only when the waiting byte is a last byte
// reset: asynchronous active-low rst_n clears the scan state, output valid, limit to 32
// depends on las_pkg, las_in_reg, las_scan
module loop_attribute_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [las_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     verdict,
    output logic                           saw_unroll,
    output logic                           saw_loop,
    output logic                           saw_count,
    output logic [las_pkg::COUNT_W-1:0]    unroll_count,
    input  logic                           cfg_we,
    input  logic [las_pkg::LIMIT_W-1:0]    cfg_wdata
);
    import las_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    las_item_t          in_item;
    las_item_t          item;
    logic               item_valid;
    logic               item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    assign in_item.code = in_byte;
    assign in_item.last = last_byte;

    las_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    las_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .limit        (limit_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .verdict      (verdict),
        .saw_unroll   (saw_unroll),
        .saw_loop     (saw_loop),
        .saw_count    (saw_count),
        .unroll_count (unroll_count)
    );

    a_conflict_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_CONFLICT |-> saw_unroll && saw_loop)
        else $error("conflict verdict without both attributes");

    a_over_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_OVER |->
            saw_count && !(saw_unroll && saw_loop)
            && unroll_count > {{(COUNT_W-LIMIT_W){1'b0}}, limit_reg})
        else $error("over-limit verdict not backed by count");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict == VERDICT_NONE || verdict == VERDICT_CONFLICT
                      || verdict == VERDICT_OVER)
        else $error("undefined verdict code");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unroll_count < 34'd10000000000)
        else $error("unroll count beyond saturation bound");

endmodule

### test/tb_loop_attribute_scanner.sv
`timescale 1ns / 100ps
// tb_loop_attribute_scanner: self-checking bench for the loop attribute scanner
// drives prefix text byte by byte, predicts each verdict and checks result transactions
// depends on las_pkg and loop_attribute_scanner
module tb_loop_attribute_scanner;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 2000;
    localparam int COUNT_BITS    = las_pkg::COUNT_W;

    localparam logic [7:0] CH_OPEN   = "[";
    localparam logic [7:0] CH_CLOSE  = "]";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_OPEN,
        SCAN_WORD,
        SCAN_AFTER_UNROLL,
        SCAN_ARG,
        SCAN_DIGITS
    } scan_phase_t;

    typedef struct {
        logic [1:0]                  verdict;
        logic                        found_unroll;
        logic                        found_loop;
        logic                        found_count;
        logic [las_pkg::COUNT_W-1:0] count;
    } prefix_verdict_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic [las_pkg::BYTE_W-1:0]    in_byte      = '0;
    logic                          last_byte    = 1'b0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic [1:0]                    verdict;
    logic                          saw_unroll;
    logic                          saw_loop;
    logic                          saw_count;
    logic [las_pkg::COUNT_W-1:0]   unroll_count;
    logic                          cfg_we       = 1'b0;
    logic [las_pkg::LIMIT_W-1:0]   cfg_wdata    = '0;

    // scanner model state
    scan_phase_t                 phase_now     = SCAN_IDLE;
    logic                        word_kind     = las_pkg::KIND_UNROLL;
    int                          word_pos      = 0;
    logic                        got_unroll    = 1'b0;
    logic                        got_loop      = 1'b0;
    logic                        got_paren     = 1'b0;
    logic [las_pkg::COUNT_W-1:0] digit_total   = '0;
    logic [las_pkg::COUNT_W-1:0] count_held    = '0;
    logic [las_pkg::LIMIT_W-1:0] limit_setting = las_pkg::LIMIT_RESET;

    prefix_verdict_t pending_verdicts[$];
    prefix_verdict_t arrived;
    logic [7:0]      prefix_text[$];
    int              mismatch_count = 0;
    int              bytes_sent     = 0;
    int              stuck_cycles   = 0;
    bit              steady         = 1'b0;
    bit              hold_request   = 1'b0;

    loop_attribute_scanner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .verdict      (verdict),
        .saw_unroll   (saw_unroll),
        .saw_loop     (saw_loop),
        .saw_count    (saw_count),
        .unroll_count (unroll_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_char(c) ||
               c == CH_UNDER;
    endfunction

    function automatic string keyword_text(input logic kind);
        if (kind == las_pkg::KIND_LOOP)
            return "loop";
        return "unroll";
    endfunction

    function automatic int word_length(input logic kind);
        string w;
        w = keyword_text(kind);
        return w.len();
    endfunction

    function automatic logic [7:0] keyword_letter(input logic kind, input int pos);
        string w;
        w = keyword_text(kind);
        return w[pos];
    endfunction

    function void note_keyword();
        if (word_kind == las_pkg::KIND_LOOP)
            got_loop = 1'b1;
        else
            got_unroll = 1'b1;
    endfunction

    function void take_digit(input logic [7:0] c);
        if (digit_total < las_pkg::COUNT_CAP)
            digit_total = digit_total * 10 + {26'd0, c - CH_ZERO};
        count_held = digit_total;
    endfunction

    function void after_unroll(input logic [7:0] c);
        if (blank_char(c))
            phase_now = SCAN_AFTER_UNROLL;
        else if (c == CH_LPAREN)
        begin
            got_paren   = 1'b1;
            digit_total = '0;
            phase_now   = SCAN_ARG;
        end
        else
            phase_now = SCAN_IDLE;
    endfunction

    function void scan_char(input logic [7:0] c);
        if (c == CH_OPEN)
        begin
            if (phase_now == SCAN_WORD && word_pos == word_length(word_kind))
                note_keyword();
            phase_now = SCAN_OPEN;
            word_pos  = 0;
        end
        else
        begin
            case (phase_now)
                SCAN_OPEN:
                begin
                    if (blank_char(c))
                        phase_now = SCAN_OPEN;
                    else if (c == "u" || c == "l")
                    begin
                        word_kind = (c == "l") ? las_pkg::KIND_LOOP : las_pkg::KIND_UNROLL;
                        word_pos  = 1;
                        phase_now = SCAN_WORD;
                    end
                    else
                        phase_now = SCAN_IDLE;
                end
                SCAN_WORD:
                begin
                    if (word_pos < word_length(word_kind))
                    begin
                        if (c == keyword_letter(word_kind, word_pos))
                            word_pos++;
                        else
                            phase_now = SCAN_IDLE;
                    end
                    else if (word_char(c))
                        phase_now = SCAN_IDLE;
                    else
                    begin
                        note_keyword();
                        if (word_kind == las_pkg::KIND_LOOP)
                            phase_now = SCAN_IDLE;
                        else
                            after_unroll(c);
                    end
                end
                SCAN_AFTER_UNROLL:
                    after_unroll(c);
                SCAN_ARG:
                begin
                    if (digit_char(c))
                    begin
                        take_digit(c);
                        phase_now = SCAN_DIGITS;
                    end
                    else if (!blank_char(c))
                        phase_now = SCAN_IDLE;
                end
                SCAN_DIGITS:
                begin
                    if (digit_char(c))
                        take_digit(c);
                    else
                        phase_now = SCAN_IDLE;
                end
                default:
                    phase_now = SCAN_IDLE;
            endcase
        end
    endfunction

    function void close_prefix();
        prefix_verdict_t res;
        if (phase_now == SCAN_WORD && word_pos == word_length(word_kind))
            note_keyword();
        if (got_unroll && got_loop)
            res.verdict = las_pkg::VERDICT_CONFLICT;
        else if (got_paren && count_held > {2'b00, limit_setting})
            res.verdict = las_pkg::VERDICT_OVER;
        else
            res.verdict = las_pkg::VERDICT_NONE;
        res.found_unroll = got_unroll;
        res.found_loop   = got_loop;
        res.found_count  = got_paren;
        res.count        = count_held;
        pending_verdicts.insert(pending_verdicts.size(), res);
        phase_now   = SCAN_IDLE;
        word_kind   = las_pkg::KIND_UNROLL;
        word_pos    = 0;
        got_unroll  = 1'b0;
        got_loop    = 1'b0;
        got_paren   = 1'b0;
        digit_total = '0;
        count_held  = '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // text generation
    function void append_byte(input logic [7:0] b);
        prefix_text.insert(prefix_text.size(), b);
    endfunction

    function void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function void push_blanks();
        logic [7:0] pool[4];
        pool = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        repeat ($urandom_range(1, 3))
            append_byte(pool[$urandom_range(0, 3)]);
    endfunction

    function void push_digits();
        longint value;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            push_text($sformatf("%0d", $urandom_range(0, 64)));
        else if (pick < 7)
        begin
            value = longint'(limit_setting) + longint'($urandom_range(0, 2)) - 1;
            if (value < 0)
                value = 0;
            push_text($sformatf("%0d", value));
        end
        else if (pick < 8)
            push_text($sformatf("000%0d", $urandom_range(0, 99)));
        else
            repeat ($urandom_range(9, 13))
                append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function void add_attribute(input bit clean);
        logic  kind;
        string word;
        int    mangle;
        int    cut;
        mangle = clean ? 0 : $urandom_range(1, 5);
        kind   = ($urandom_range(0, 9) < 6 || mangle == 5) ? las_pkg::KIND_UNROLL
                                                           : las_pkg::KIND_LOOP;
        word   = keyword_text(kind);
        if (mangle != 1)
            append_byte(CH_OPEN);
        if ($urandom_range(0, 3) == 0)
            push_blanks();
        case (mangle)
            2:
            begin
                cut = $urandom_range(1, word.len() - 1);
                for (int i = 0; i < cut; i++)
                    append_byte(word[i]);
                append_byte(8'($urandom_range(0, 255)));
            end
            3:
            begin
                push_text(word);
                append_byte(($urandom_range(0, 1) == 0) ? CH_UNDER : "x");
            end
            4:
            begin
                append_byte(word[0] - 8'd32);
                for (int i = 1; i < word.len(); i++)
                    append_byte(word[i]);
            end
            default:
            begin
                push_text(word);
                if (kind == las_pkg::KIND_UNROLL && ($urandom_range(0, 2) != 0 || mangle == 5))
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_blanks();
                    append_byte(CH_LPAREN);
                    if ($urandom_range(0, 3) == 0)
                        push_blanks();
                    if (mangle == 5)
                        push_text(($urandom_range(0, 1) == 0) ? " )" : "n)");
                    else
                        push_digits();
                    if ($urandom_range(0, 3) == 0)
                        push_blanks();
                    append_byte(CH_RPAREN);
                end
                else if ($urandom_range(0, 3) == 0)
                    push_blanks();
                append_byte(CH_CLOSE);
            end
        endcase
    endfunction

    function void add_filler();
        case ($urandom_range(0, 5))
            0: push_text("for(;;)");
            1: push_text(" a[i] ");
            2: push_text("\n");
            3: push_text("{ x++; }");
            4: push_text("[[ ]]");
            default: push_text("(12)");
        endcase
    endfunction

    function void build_prefix();
        int pick;
        int cut;
        prefix_text.delete();
        repeat ($urandom_range(1, 3))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                add_attribute(1'b1);
            else if (pick < 80)
                add_attribute(1'b0);
            else if (pick < 90)
                add_filler();
            else
                repeat ($urandom_range(1, 6))
                    append_byte(8'($urandom_range(0, 255)));
        end
        // sometimes end the prefix in the middle of an attribute
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, prefix_text.size());
            while (prefix_text.size() > cut)
                void'(prefix_text.pop_back());
        end
    endfunction

    // stimulus
    task automatic send_char(input logic [7:0] code, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= code;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        scan_char(code);
        if (fin)
            close_prefix();
    endtask

    task automatic send_prefix();
        for (int i = 0; i < prefix_text.size(); i++)
            send_char(prefix_text[i], i == prefix_text.size() - 1);
    endtask

    task automatic send_text(input string s);
        prefix_text.delete();
        push_text(s);
        send_prefix();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [las_pkg::LIMIT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        limit_setting  = value;
    endtask

    task automatic test_directed();
        // keyword at the end, bracket inside a match, argument without digits, lone 0xff byte
        send_text("[loop");
        send_text("[unroll[loop");
        send_text("[unroll(");
        prefix_text.delete();
        append_byte(8'hff);
        send_prefix();
    endtask

    task automatic test_random_text(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            build_prefix();
            send_prefix();
        end
    endtask

    task automatic test_backpressure();
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (40)
        begin
            prefix_text.delete();
            add_attribute(1'b1);
            send_prefix();
        end
        steady = 1'b0;
    endtask

    task automatic test_steady_stream(input int budget);
        steady = 1'b1;
        test_random_text(budget);
        steady = 1'b0;
    endtask

    // result side ready with random pauses and one long hold
    initial
    begin
        int hold_left;
        int pause_left;
        hold_left  = 0;
        pause_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (pause_left > 0)
            begin
                pause_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                pause_left  = pick_gap();
            end
        end
    end

    task automatic compare_field(input string name, input logic [las_pkg::COUNT_W-1:0] want,
                                 input logic [las_pkg::COUNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none actual verdict %0d",
                         $time, verdict);
                mismatch_count++;
            end
            else
            begin
                arrived = pending_verdicts.pop_front();
                compare_field("verdict", COUNT_BITS'(arrived.verdict), COUNT_BITS'(verdict));
                compare_field("saw_unroll", COUNT_BITS'(arrived.found_unroll),
                              COUNT_BITS'(saw_unroll));
                compare_field("saw_loop", COUNT_BITS'(arrived.found_loop),
                              COUNT_BITS'(saw_loop));
                compare_field("saw_count", COUNT_BITS'(arrived.found_count),
                              COUNT_BITS'(saw_count));
                compare_field("unroll_count", arrived.count, unroll_count);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_text(120);
        write_limit(32'd0);
        test_random_text(300);
        write_limit(32'hffff_ffff);
        test_random_text(300);
        write_limit(32'd1_000_000_000);
        test_backpressure();
        write_limit($urandom());
        test_steady_stream(200);
        write_limit(32'd1);
        test_random_text(250);
        settle();
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
